### rtl/crc16_pkg.sv
// crc16_pkg: types, command and register codes, and bit-reversal helpers
// shared by the configurable crc-16 engine; depends on nothing
`default_nettype none

package crc16_pkg;

    localparam int CRC_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CRC_W-1:0] POLY_RESET  = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RESET  = 16'hFFFF;
    localparam logic [CRC_W-1:0] FXOR_RESET  = 16'h0000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_FEED_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEED_GROUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_INPUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUTPUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR      = 3'd4;

    localparam logic [SIZE_W-1:0] GROUP_MAX = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_in;
        logic [SIZE_W-1:0] group_size;
    } crc16_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_out;
        logic [CRC_W-1:0] remainder_out;
    } crc16_result_t;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] initial_value;
        logic             reflect_input;
        logic             reflect_output;
        logic [CRC_W-1:0] final_xor;
    } crc16_cfg_t;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/crc16_configurable_engine.sv
// crc16_configurable_engine: an item is registered in the item register, its result in
// the result register; throughput one item per cycle; eight unrolled bit steps sit
// between the two registers, and only a stalled result holds the input
// asynchronous active-low reset: remainder 0xffff, polynomial 0x1021,
// initial value 0xffff, reflections and final xor 0
// depends on crc16_pkg, crc16_cfg and crc16_step
`default_nettype none

module crc16_configurable_engine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire crc16_pkg::crc16_item_t           item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output crc16_pkg::crc16_result_t              result,
    input  wire logic                             cfg_we,
    input  wire logic [crc16_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crc16_pkg::CRC_W-1:0]      cfg_data
);
    import crc16_pkg::*;

    crc16_cfg_t    cfg;
    crc16_item_t   item_reg;
    logic          item_full_reg;
    logic          item_full_next;
    crc16_result_t result_reg;
    logic          result_full_reg;
    logic          result_full_next;
    logic [CRC_W-1:0] remainder_reg;
    logic [CRC_W-1:0] remainder_next;
    crc16_result_t step_result;
    logic          advance;
    logic          item_xfer;

    crc16_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc16_step u_step (
        .item           (item_reg),
        .cfg            (cfg),
        .remainder      (remainder_reg),
        .remainder_next (remainder_next),
        .result         (step_result)
    );

    // the result register moves on when empty or when its transfer completes
    assign advance    = !result_full_reg || !result_stall;
    assign item_stall = item_full_reg && !advance;
    assign item_xfer  = item_valid && !item_stall;

    always_comb
    begin
        item_full_next   = item_full_reg;
        result_full_next = result_full_reg;
        if (advance)
        begin
            result_full_next = item_full_reg;
            item_full_next   = 1'b0;
        end
        if (item_xfer)
        begin
            item_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg   <= 1'b0;
            result_full_reg <= 1'b0;
            remainder_reg   <= INIT_RESET;
        end
        else
        begin
            item_full_reg   <= item_full_next;
            result_full_reg <= result_full_next;
            if (advance && item_full_reg)
            begin
                remainder_reg <= remainder_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            item_reg <= item;
        end
        if (advance && item_full_reg)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_full_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_stall_only_when_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && item_full_reg)
    ) else $error("item stall without a held result");

    a_remainder_tracks_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.remainder_out == remainder_reg)
    ) else $error("running remainder differs from reported remainder");

    a_restart_loads_initial: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && item_full_reg && item_reg.cmd == CMD_RESTART)
            |=> (result.remainder_out == $past(cfg.initial_value))
    ) else $error("restart did not load the initial value");
`endif

endmodule

`default_nettype wire

### rtl/crc16_cfg.sv
// crc16_cfg: configuration register file of the crc-16 engine
// depends on crc16_pkg
`default_nettype none

module crc16_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [crc16_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crc16_pkg::CRC_W-1:0]      cfg_data,
    output crc16_pkg::crc16_cfg_t                 cfg
);
    import crc16_pkg::*;

    crc16_cfg_t cfg_reg;
    crc16_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLYNOMIAL:     cfg_next.polynomial     = cfg_data;
                REG_INITIAL_VALUE:  cfg_next.initial_value  = cfg_data;
                REG_REFLECT_INPUT:  cfg_next.reflect_input  = cfg_data[0];
                REG_REFLECT_OUTPUT: cfg_next.reflect_output = cfg_data[0];
                REG_FINAL_XOR:      cfg_next.final_xor      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polynomial     <= POLY_RESET;
            cfg_reg.initial_value  <= INIT_RESET;
            cfg_reg.reflect_input  <= 1'b0;
            cfg_reg.reflect_output <= 1'b0;
            cfg_reg.final_xor      <= FXOR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/crc16_step.sv
// crc16_step: one item's update of the running remainder, eight unrolled
// bit steps, plus output reflection and final xor; depends on crc16_pkg
`default_nettype none

module crc16_step (
    input  wire crc16_pkg::crc16_item_t       item,
    input  wire crc16_pkg::crc16_cfg_t        cfg,
    input  wire logic [crc16_pkg::CRC_W-1:0]  remainder,
    output logic [crc16_pkg::CRC_W-1:0]       remainder_next,
    output crc16_pkg::crc16_result_t          result
);
    import crc16_pkg::*;

    logic [BYTE_W-1:0] bits;
    logic [SIZE_W-1:0] count;
    logic [CRC_W-1:0]  shown;

    // bits are left-aligned so that the first one fed sits in bit 7
    always_comb
    begin
        bits  = '0;
        count = '0;
        unique case (item.cmd)
            CMD_FEED_BYTE:
            begin
                bits  = cfg.reflect_input ? rev8(item.data_in) : item.data_in;
                count = GROUP_MAX;
            end
            CMD_FEED_GROUP:
            begin
                if (item.group_size != '0 && item.group_size <= GROUP_MAX)
                begin
                    bits  = item.data_in << (GROUP_MAX - item.group_size);
                    count = item.group_size;
                end
            end
            CMD_RESTART, CMD_UNUSED:
            begin
                bits  = '0;
                count = '0;
            end
            default:
            begin
                bits  = '0;
                count = '0;
            end
        endcase
    end

    always_comb
    begin
        logic [CRC_W-1:0] r;
        logic             fb;
        r = remainder;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb = r[CRC_W-1] ^ bits[BYTE_W-1-i];
            if (SIZE_W'(i) < count)
            begin
                r = {r[CRC_W-2:0], 1'b0} ^ (fb ? cfg.polynomial : '0);
            end
        end
        remainder_next = (item.cmd == CMD_RESTART) ? cfg.initial_value : r;
    end

    assign shown                = cfg.reflect_output ? rev16(remainder_next) : remainder_next;
    assign result.crc_out       = shown ^ cfg.final_xor;
    assign result.remainder_out = remainder_next;

endmodule

`default_nettype wire

### verif/crc16_configurable_engine_checker.sv
// crc16_configurable_engine_checker: watches the item, result and register ports,
// keeps its own copy of the crc state and compares every result transfer
// depends on crc16_pkg for the payload types, command codes and register indexes

module crc16_configurable_engine_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    input  wire logic                             item_stall,
    input  crc16_pkg::crc16_item_t                item,
    input  wire logic                             result_valid,
    input  wire logic                             result_stall,
    input  crc16_pkg::crc16_result_t              result,
    input  wire logic                             cfg_we,
    input  wire logic [crc16_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crc16_pkg::CRC_W-1:0]      cfg_data,
    output int                                    fail_count,
    output int                                    pending
);
    import crc16_pkg::*;

    localparam int PRINT_CAP = 60;

    crc16_cfg_t       cfg_shadow;
    logic [CRC_W-1:0] crc_state;
    crc16_result_t    crc_expected[$];
    crc16_result_t    next_res;
    crc16_result_t    want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // one step of the standard form: feedback is top bit xor data bit
    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] rem,
                                                   input logic [CRC_W-1:0] poly,
                                                   input logic             bit_in);
        logic fb;
        fb = rem[CRC_W-1] ^ bit_in;
        return {rem[CRC_W-2:0], 1'b0} ^ (fb ? poly : '0);
    endfunction

    function automatic crc16_result_t predict_crc(input crc16_item_t      it,
                                                  input crc16_cfg_t       c,
                                                  input logic [CRC_W-1:0] rem);
        crc16_result_t    res;
        logic [CRC_W-1:0] shown;
        int               i;
        case (it.cmd)
            CMD_FEED_BYTE:
            begin
                // reflected input means the byte goes in lsb first
                for (i = 0; i < BYTE_W; i++)
                begin
                    rem = crc_shift(rem, c.polynomial,
                                    c.reflect_input ? it.data_in[i] : it.data_in[BYTE_W-1-i]);
                end
            end
            CMD_FEED_GROUP:
            begin
                if (it.group_size >= 1 && it.group_size <= GROUP_MAX)
                begin
                    for (i = int'(it.group_size) - 1; i >= 0; i--)
                    begin
                        rem = crc_shift(rem, c.polynomial, it.data_in[i]);
                    end
                end
            end
            CMD_RESTART:
            begin
                rem = c.initial_value;
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < CRC_W; i++)
        begin
            shown[i] = c.reflect_output ? rem[CRC_W-1-i] : rem[i];
        end
        res.crc_out       = shown ^ c.final_xor;
        res.remainder_out = rem;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_shadow.polynomial     = POLY_RESET;
            cfg_shadow.initial_value  = INIT_RESET;
            cfg_shadow.reflect_input  = 1'b0;
            cfg_shadow.reflect_output = 1'b0;
            cfg_shadow.final_xor      = FXOR_RESET;
            crc_state                 = INIT_RESET;
            crc_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POLYNOMIAL:     cfg_shadow.polynomial     = cfg_data;
                    REG_INITIAL_VALUE:  cfg_shadow.initial_value  = cfg_data;
                    REG_REFLECT_INPUT:  cfg_shadow.reflect_input  = cfg_data[0];
                    REG_REFLECT_OUTPUT: cfg_shadow.reflect_output = cfg_data[0];
                    REG_FINAL_XOR:      cfg_shadow.final_xor      = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (item_valid && !item_stall)
            begin
                next_res  = predict_crc(item, cfg_shadow, crc_state);
                crc_state = next_res.remainder_out;
                crc_expected.push_back(next_res);
            end
            if (result_valid && !result_stall)
            begin
                if (crc_expected.size() == 0)
                begin
                    report_mismatch(
                        $sformatf("result transfer with nothing expected, crc %h rem %h",
                                  result.crc_out, result.remainder_out));
                end
                else
                begin
                    want = crc_expected.pop_front();
                    if (result.crc_out !== want.crc_out)
                    begin
                        report_mismatch($sformatf("crc_out got %h expected %h",
                                                  result.crc_out, want.crc_out));
                    end
                    if (result.remainder_out !== want.remainder_out)
                    begin
                        report_mismatch($sformatf("remainder_out got %h expected %h",
                                                  result.remainder_out, want.remainder_out));
                    end
                end
            end
            pending <= crc_expected.size();
        end
    end

endmodule

### verif/crc16_configurable_engine_tb.sv
// crc16_configurable_engine_tb: clock, reset and stimulus for the crc-16 engine,
// with directed items, several register settings and random traffic with and without back-pressure
// depends on crc16_pkg, crc16_configurable_engine and crc16_configurable_engine_checker

module crc16_configurable_engine_tb;

    import crc16_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASES       = 6;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    crc16_item_t          item         = '0;
    logic                 result_stall = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CRC_W-1:0]     cfg_data     = '0;

    logic                 item_stall;
    logic                 result_valid;
    crc16_result_t        result;
    int                   fail_count;
    int                   pending;

    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int phase;
    int n;

    crc16_configurable_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    crc16_configurable_engine_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic crc16_item_t make_item(input logic [CMD_W-1:0]  cmd,
                                              input logic [BYTE_W-1:0] data,
                                              input logic [SIZE_W-1:0] size);
        crc16_item_t it;
        it.cmd        = cmd;
        it.data_in    = data;
        it.group_size = size;
        return it;
    endfunction

    function automatic crc16_item_t random_crc_item();
        crc16_item_t it;
        int          r;
        r             = int'($urandom_range(99));
        it.data_in    = BYTE_W'($urandom_range(255));
        it.group_size = SIZE_W'($urandom_range(15));
        if (r < 45)
        begin
            it.cmd = CMD_FEED_BYTE;
        end
        else if (r < 78)
        begin
            it.cmd = CMD_FEED_GROUP;
            // mostly legal group sizes, now and then anything the field holds
            if ($urandom_range(4) != 0)
            begin
                it.group_size = SIZE_W'($urandom_range(8, 1));
            end
        end
        else if (r < 92)
        begin
            it.cmd = CMD_RESTART;
        end
        else
        begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(input crc16_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
    endtask

    // hold off the sender until every result transfer has come back
    task automatic drain();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic load_config(input logic [CRC_W-1:0] poly,
                               input logic [CRC_W-1:0] init,
                               input logic [CRC_W-1:0] refl_in,
                               input logic [CRC_W-1:0] refl_out,
                               input logic [CRC_W-1:0] fxor);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POLYNOMIAL;
        cfg_data  <= poly;
        @(posedge clk);
        cfg_index <= REG_INITIAL_VALUE;
        cfg_data  <= init;
        @(posedge clk);
        cfg_index <= REG_REFLECT_INPUT;
        cfg_data  <= refl_in;
        @(posedge clk);
        cfg_index <= REG_REFLECT_OUTPUT;
        cfg_data  <= refl_out;
        @(posedge clk);
        cfg_index <= REG_FINAL_XOR;
        cfg_data  <= fxor;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct  = 30;
        stall_pct = 69;

        // reset settings: byte and data extremes, every group size class, unused command
        send_item(make_item(CMD_RESTART,    8'h3C, 4'd6));
        send_item(make_item(CMD_FEED_BYTE,  8'h00, 4'd0));
        send_item(make_item(CMD_FEED_BYTE,  8'hFF, 4'd15));
        send_item(make_item(CMD_FEED_GROUP, 8'hFF, 4'd0));
        send_item(make_item(CMD_FEED_GROUP, 8'h01, 4'd1));
        send_item(make_item(CMD_FEED_GROUP, 8'h00, 4'd8));
        send_item(make_item(CMD_FEED_GROUP, 8'hFF, 4'd8));
        send_item(make_item(CMD_FEED_GROUP, 8'hF5, 4'd3));
        send_item(make_item(CMD_FEED_GROUP, 8'hFF, 4'd9));
        send_item(make_item(CMD_FEED_GROUP, 8'hAA, 4'd15));
        send_item(make_item(CMD_UNUSED,     8'h55, 4'd7));
        send_item(make_item(CMD_FEED_BYTE,  8'h31, 4'd8));

        // both reflections on: a bit group must not be reflected
        drain();
        load_config(16'h8005, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_item(make_item(CMD_RESTART,    8'hFF, 4'd15));
        send_item(make_item(CMD_FEED_BYTE,  8'h01, 4'd0));
        send_item(make_item(CMD_FEED_BYTE,  8'h80, 4'd2));
        send_item(make_item(CMD_FEED_GROUP, 8'h01, 4'd8));
        send_item(make_item(CMD_FEED_GROUP, 8'h80, 4'd8));
        send_item(make_item(CMD_FEED_GROUP, 8'h01, 4'd1));
        send_item(make_item(CMD_UNUSED,     8'hFF, 4'd15));
        send_item(make_item(CMD_RESTART,    8'h00, 4'd0));

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase < 2)
            begin
                idle_pct  = 30;
                stall_pct = 69;
            end
            else if (phase < 4)
            begin
                idle_pct  = 69;
                stall_pct = 30;
            end
            else
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            case (phase)
                0: load_config(16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001, 16'hFFFF);
                1: load_config(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0000);
                3: load_config(16'h8005, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
                5: load_config(16'h0001, 16'h8000, 16'h0000, 16'h0000,
                               16'($urandom_range(65535)));
                default: load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                     16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                     16'($urandom_range(65535)));
            endcase
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if ($urandom_range(59) == 0)
                begin
                    drain();
                end
                send_item(random_crc_item());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
